>>> rtl/lbac_pkg.sv
// lbac_pkg: types, constants and helper functions for the label boundary adjacency counter
// no dependencies; imported by every module of the block
package lbac_pkg;

  // sizing
  localparam int MAX_LABELS = 64;
  localparam int LBL_IDX_W  = $clog2(MAX_LABELS);
  localparam int MAX_ROWS   = 1024;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COUNT_BITS = 32;
  localparam int PAIR_AW    = 2 * LBL_IDX_W;

  // field widths fixed by the interface
  localparam int LABEL_W  = 8;
  localparam int HEIGHT_W = 11;
  localparam int LCOUNT_W = 7;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // item modes
  localparam logic [1:0] MODE_PIXEL    = 2'd0;
  localparam logic [1:0] MODE_READ     = 2'd1;
  localparam logic [1:0] MODE_READ_CLR = 2'd2;
  localparam logic [1:0] MODE_IDLE     = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT   = 1'd1;

  typedef struct packed {
    logic [1:0]           mode;
    logic [LABEL_W-1:0]   label;
    logic                 first_pixel;
    logic [LBL_IDX_W-1:0] label_a;
    logic [LBL_IDX_W-1:0] label_b;
  } in_t;

  typedef struct packed {
    logic [31:0] count;
    logic        bad_label;
    logic        saturated;
  } out_t;

  // one-based label is usable when non-zero and within the effective label count
  function automatic logic label_ok(input logic [LABEL_W-1:0] lab,
                                    input logic [LCOUNT_W-1:0] eff);
    return (lab != '0) && (lab <= {{(LABEL_W-LCOUNT_W){1'b0}}, eff});
  endfunction

  // upper triangle address of two one-based labels: row smaller, column larger
  function automatic logic [PAIR_AW-1:0] pair_addr(input logic [LABEL_W-1:0] x,
                                                   input logic [LABEL_W-1:0] y);
    logic [LABEL_W-1:0] lo;
    logic [LABEL_W-1:0] hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    lo = lo - 1'b1;
    hi = hi - 1'b1;
    return {lo[LBL_IDX_W-1:0], hi[LBL_IDX_W-1:0]};
  endfunction

  // saturating increment
  function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

>>> rtl/lbac_ram.sv
// lbac_ram: simple dual-port synchronous ram, one write and one read port
// read-first, registered read data; uses lbac_pkg
module lbac_ram
  import lbac_pkg::*;
#(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wa,
  input  logic [DATA_W-1:0] wd,
  input  logic [ADDR_W-1:0] ra,
  output logic [DATA_W-1:0] rd
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // old data on a same-address collision
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

>>> rtl/label_boundary_adjacency_counter.sv
// label_boundary_adjacency_counter: top level, pixel and read pipeline around the count ram
// depends on lbac_pkg and lbac_ram (line store and boundary count table)
//
//  channel   direction  handshake            beat
//  in        into block in_valid / in_stall  in_t  (mode, label, first_pixel, label_a, label_b)
//  out       from block out_valid / out_stall out_t (count, bad_label, saturated)
//  cfg       into block cfg_we               cfg_index, cfg_data
//
// no beat is taken in the first phase: each pixel makes two read-modify-writes
// on the single read port of the count ram, so the front end accepts only while the stage
// is empty or in its second phase
// after reset the count ram is swept to zero, all 4096 entries, with in_stall held high
// a two-entry result queue lets the stage keep working while out_stall is high;
// in_stall also rises once that queue plus the work in flight would fill it
module label_boundary_adjacency_counter
  import lbac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [HEIGHT_W-1:0] column_height;
  logic [LCOUNT_W-1:0] label_count;

  // image scan state
  logic [LABEL_W-1:0] prev_label;
  logic [ROW_W-1:0]   row_pos;
  logic               in_first_col;

  // count ram sweep after reset
  logic               clr_done;
  logic [PAIR_AW-1:0] clr_addr;

  // stage registers
  logic                  st_valid;
  logic                  st_ph2;
  logic [1:0]            st_mode;
  logic [LABEL_W-1:0]    st_label;
  logic                  st_first_col;
  logic                  st_v1;
  logic [PAIR_AW-1:0]    st_a1;
  logic                  st_v2;
  logic [PAIR_AW-1:0]    st_a2;
  logic                  st_bad;
  logic                  st_sat;
  logic [COUNT_BITS-1:0] st_count;

  // result queue
  out_t       fifo_mem [2];
  logic       fifo_wp;
  logic       fifo_rp;
  logic [1:0] fifo_cnt;
  logic       fifo_push;
  logic       fifo_pop;
  out_t       result;

  // ram ports
  logic                  cnt_we;
  logic [PAIR_AW-1:0]    cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [PAIR_AW-1:0]    cnt_ra;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  fwd_hit;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_incr;
  logic                  ls_we;
  logic [LABEL_W-1:0]    ls_rd;

  // front end decode
  logic                  in_acc;
  logic                  ph1;
  logic                  ph2;
  logic [LCOUNT_W-1:0]   eff_labels;
  logic [HEIGHT_W-1:0]   h_eff;
  logic [ROW_W-1:0]      row_eff;
  logic                  first_col_eff;
  logic [HEIGHT_W-1:0]   row_inc;
  logic                  row_wrap;
  logic                  in_pixel;
  logic                  v1_in;
  logic [PAIR_AW-1:0]    a1_in;
  logic [LBL_IDX_W-1:0]  rd_lo;
  logic [LBL_IDX_W-1:0]  rd_hi;
  logic                  v2_calc;
  logic [PAIR_AW-1:0]    a2_calc;
  logic                  sat1;
  logic                  sat2;

  assign ph1 = st_valid && !st_ph2;
  assign ph2 = st_valid && st_ph2;

  // take a beat only after the sweep, where the read port is free and the queue has room for its result
  assign in_stall = !(clr_done && !ph1 && ({1'b0, fifo_cnt} + {2'b00, st_valid} < 3'd2));
  assign in_acc   = in_valid && !in_stall;
  assign in_pixel = (in_data.mode == MODE_PIXEL);

  assign eff_labels = (label_count > LCOUNT_W'(MAX_LABELS)) ? LCOUNT_W'(MAX_LABELS) : label_count;

  always_comb begin
    h_eff = column_height;
    if (column_height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (column_height > HEIGHT_W'(MAX_ROWS)) begin
      h_eff = HEIGHT_W'(MAX_ROWS);
    end
  end

  // position of the incoming pixel
  assign row_eff       = in_data.first_pixel ? '0 : row_pos;
  assign first_col_eff = in_data.first_pixel ? 1'b1 : in_first_col;
  assign row_inc       = {{(HEIGHT_W-ROW_W){1'b0}}, row_eff} + 1'b1;
  assign row_wrap      = (row_inc >= h_eff);

  // neighbour above in the same column
  assign v1_in = (row_eff != '0) && (prev_label != in_data.label)
                 && label_ok(prev_label, eff_labels) && label_ok(in_data.label, eff_labels);

  // read modes address the table with zero-based labels
  assign rd_lo = (in_data.label_a < in_data.label_b) ? in_data.label_a : in_data.label_b;
  assign rd_hi = (in_data.label_a < in_data.label_b) ? in_data.label_b : in_data.label_a;
  assign a1_in = in_pixel ? pair_addr(prev_label, in_data.label) : {rd_lo, rd_hi};

  // neighbour in the previous column, from the line store
  assign v2_calc = !st_first_col && (ls_rd != st_label)
                   && label_ok(ls_rd, eff_labels) && label_ok(st_label, eff_labels);
  assign a2_calc = pair_addr(ls_rd, st_label);

  // count ram read data, with the write of the same cycle forwarded
  assign cnt_cur  = fwd_hit ? fwd_data : cnt_rd;
  assign cnt_incr = count_inc(cnt_cur);
  assign sat1     = st_v1 && (cnt_incr == COUNT_MAX);
  assign sat2     = st_v2 && (cnt_incr == COUNT_MAX);

  // count ram ports: sweep, then first bump or clear, then second bump
  assign cnt_ra = ph1 ? a2_calc : a1_in;

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = st_a1;
    cnt_wd = cnt_incr;
    if (!clr_done) begin
      cnt_we = 1'b1;
      cnt_wa = clr_addr;
      cnt_wd = '0;
    end else if (ph1) begin
      case (st_mode)
        MODE_PIXEL: begin
          cnt_we = st_v1;
        end
        MODE_READ_CLR: begin
          cnt_we = 1'b1;
          cnt_wd = '0;
        end
        default: begin
          cnt_we = 1'b0;
        end
      endcase
    end else if (ph2) begin
      cnt_we = (st_mode == MODE_PIXEL) && st_v2;
      cnt_wa = st_a2;
    end
  end

  always_ff @(posedge clk) begin
    fwd_hit  <= cnt_we && (cnt_wa == cnt_ra);
    fwd_data <= cnt_wd;
  end

  lbac_ram #(
    .ADDR_W(PAIR_AW),
    .DATA_W(COUNT_BITS)
  ) u_count_ram (
    .clk(clk),
    .we (cnt_we),
    .wa (cnt_wa),
    .wd (cnt_wd),
    .ra (cnt_ra),
    .rd (cnt_rd)
  );

  // line store: read the old label of this row and overwrite it in the same cycle
  assign ls_we = in_acc && in_pixel;

  lbac_ram #(
    .ADDR_W(ROW_W),
    .DATA_W(LABEL_W)
  ) u_line_store (
    .clk(clk),
    .we (ls_we),
    .wa (row_eff),
    .wd (in_data.label),
    .ra (row_eff),
    .rd (ls_rd)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      column_height <= HEIGHT_W'(1);
      label_count   <= LCOUNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMN_HEIGHT: column_height <= cfg_data[HEIGHT_W-1:0];
        CFG_LABEL_COUNT:   label_count   <= cfg_data[LCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // count ram sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_done <= 1'b0;
      clr_addr <= '0;
    end else if (!clr_done) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clr_done <= 1'b1;
      end
    end
  end

  // scan position, moved on at each pixel beat
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_label   <= '0;
      row_pos      <= '0;
      in_first_col <= 1'b1;
    end else if (in_acc && in_pixel) begin
      prev_label   <= in_data.label;
      row_pos      <= row_wrap ? '0 : row_inc[ROW_W-1:0];
      in_first_col <= row_wrap ? 1'b0 : first_col_eff;
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      st_ph2   <= 1'b0;
    end else if (in_acc) begin
      st_valid <= 1'b1;
      st_ph2   <= 1'b0;
    end else if (ph1) begin
      st_ph2 <= 1'b1;
    end else if (ph2) begin
      st_valid <= 1'b0;
      st_ph2   <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_mode      <= in_data.mode;
      st_label     <= in_data.label;
      st_first_col <= first_col_eff;
      st_v1        <= in_pixel && v1_in;
      st_a1        <= a1_in;
      st_bad       <= in_pixel && !label_ok(in_data.label, eff_labels);
      st_sat       <= 1'b0;
      st_count     <= '0;
      st_v2        <= 1'b0;
      st_a2        <= '0;
    end else if (ph1) begin
      case (st_mode)
        MODE_PIXEL: begin
          st_sat <= sat1;
          st_v2  <= v2_calc;
          st_a2  <= a2_calc;
        end
        MODE_READ, MODE_READ_CLR: begin
          st_count <= cnt_cur;
        end
        default: begin
        end
      endcase
    end
  end

  // result of the item in its second phase
  always_comb begin
    result.count     = 32'(st_count);
    result.bad_label = st_bad;
    result.saturated = (st_mode == MODE_PIXEL) && (st_sat || sat2);
  end

  // result queue
  assign fifo_push = ph2;
  assign out_valid = (fifo_cnt != 2'd0);
  assign fifo_pop  = out_valid && !out_stall;
  assign out_data  = fifo_mem[fifo_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wp  <= 1'b0;
      fifo_rp  <= 1'b0;
      fifo_cnt <= 2'd0;
    end else begin
      if (fifo_push) begin
        fifo_wp <= !fifo_wp;
      end
      if (fifo_pop) begin
        fifo_rp <= !fifo_rp;
      end
      if (fifo_push && !fifo_pop) begin
        fifo_cnt <= fifo_cnt + 1'b1;
      end else if (!fifo_push && fifo_pop) begin
        fifo_cnt <= fifo_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[fifo_wp] <= result;
    end
  end

`ifndef SYNTHESIS
  // the queue never takes a result it has no room for
  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    (fifo_push && !fifo_pop) |-> (fifo_cnt != 2'd2))
    else $error("result queue overflow");

  // the first phase always moves on to the second
  a_ph1_adv: assert property (@(posedge clk) disable iff (rst)
    ph1 |=> ph2)
    else $error("stage stuck in first phase");

  // no beat taken while the count ram is still being swept
  a_no_acc_clr: assert property (@(posedge clk) disable iff (rst)
    !clr_done |-> !in_acc)
    else $error("beat taken during count ram sweep");
`endif

endmodule
